[design/lzss_pixel_decompressor_macros.svh]
// assertion macros for the lzss pixel decompressor
`ifndef LZSS_PIXEL_DECOMPRESSOR_MACROS_SVH
`define LZSS_PIXEL_DECOMPRESSOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define LZPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzpd check failed");

// next-cycle implication, checked out of reset
`define LZPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzpd check failed");

`endif

[design/lzpd_pkg.sv]
// shared constants and widths for the lzss pixel decompressor
package lzpd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;

  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 20;
  localparam int OFS_W   = 12;
  localparam int RUN_W   = 6;
  localparam int FLAG_W  = 4;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL = 1'b1;

  localparam logic [FLAG_W-1:0] FLAGS_PER_CTRL = 4'd8;
  localparam logic [RUN_W-1:0]  LEN_BIAS       = 6'd3;

endpackage

[design/lzpd_window.sv]
// history window memory: one write port, one registered read port
module lzpd_window #(
  parameter int WINDOW_DEPTH = lzpd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]    wr_addr,
  input  logic [lzpd_pkg::BYTE_W-1:0]        wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]    rd_addr,
  output logic [lzpd_pkg::BYTE_W-1:0]        rd_data
);
  import lzpd_pkg::*;

  logic [BYTE_W-1:0] mem [WINDOW_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/lzss_pixel_decompressor.sv]
// lzss pixel decompressor top level: byte parser, copy sequencer, output register
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_stall    in_stream_byte
//  out       out  out_valid / out_stall  out_pixel_value, out_last_of_run, out_image_done
//  cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// control, literal and command low bytes are each handled in the idle state
// a command high byte starts a run of n pixels (n <= 34, n <= 18 in short mode): each
//   pixel is a window read state then a write-and-emit state on the registered read port
// rst_n is synchronous; the history window is not cleared and needs no sweep
// out_stall holds the pixel in the output register; in_stall is high while a copy
//   runs or while a pixel waits in the output register
module lzss_pixel_decompressor #(
  parameter int WINDOW_DEPTH = lzpd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lzpd_pkg::BYTE_W-1:0]       in_stream_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lzpd_pkg::BYTE_W-1:0]       out_pixel_value,
  output logic                              out_last_of_run,
  output logic                              out_image_done,
  input  logic                              cfg_we,
  input  logic [lzpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lzpd_pkg::CFG_W-1:0]        cfg_wdata
);
  import lzpd_pkg::*;

  `include "lzss_pixel_decompressor_macros.svh"

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int SW = AW + 1;
  localparam int DW = (SW > OFS_W) ? SW : OFS_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_CONTROL = 3'b001,
    PH_ITEM    = 3'b010,
    PH_HIGH    = 3'b100
  } phase_t;

  seq_state_t         state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic               short_mode_r, short_mode_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] produced_r, produced_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [BYTE_W-1:0]  flag_shift_r, flag_shift_nxt;
  logic [FLAG_W-1:0]  flags_left_r, flags_left_nxt;
  logic [BYTE_W-1:0]  cmd_low_r, cmd_low_nxt;
  logic [RUN_W-1:0]   remain_r, remain_nxt;
  logic [OFS_W-1:0]   offset_r, offset_nxt;
  logic               ofs_big_r, ofs_big_nxt;
  logic               bad_r, bad_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  pixel_r, pixel_nxt;
  logic               last_r, last_nxt;
  logic               done_r, done_nxt;

  logic               in_fire;
  logic               out_free;
  logic               complete;
  logic               load_out;
  logic [TOTAL_W-1:0] produced_inc;
  logic [AW-1:0]      wp_inc;
  logic [15:0]        cmd_word;
  logic [SW-1:0]      src_diff;
  logic [SW-1:0]      src_wrap;
  logic [AW-1:0]      src_addr;

  logic               wr_en;
  logic [BYTE_W-1:0]  wr_data;
  logic               rd_en;
  logic [BYTE_W-1:0]  rd_data;

  lzpd_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (src_addr),
    .rd_data (rd_data)
  );

  assign out_free     = !out_valid_r || !out_stall;
  assign in_stall     = (state_r != S_IDLE) || !out_free;
  assign in_fire      = in_valid && !in_stall;
  assign complete     = produced_r >= total_r;
  assign produced_inc = produced_r + TOTAL_W'(1);
  assign wp_inc       = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign cmd_word     = {in_stream_byte, cmd_low_r};

  // source = write pointer minus offset, wrapped into the window
  assign src_diff = {1'b0, wp_r} - SW'(offset_r);
  assign src_wrap = src_diff + SW'(WINDOW_DEPTH);
  assign src_addr = src_diff[SW-1] ? src_wrap[AW-1:0] : src_diff[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    short_mode_nxt = short_mode_r;
    total_nxt      = total_r;
    produced_nxt   = produced_r;
    wp_nxt         = wp_r;
    flag_shift_nxt = flag_shift_r;
    flags_left_nxt = flags_left_r;
    cmd_low_nxt    = cmd_low_r;
    remain_nxt     = remain_r;
    offset_nxt     = offset_r;
    ofs_big_nxt    = ofs_big_r;
    bad_nxt        = bad_r;
    pixel_nxt      = pixel_r;
    last_nxt       = last_r;
    done_nxt       = done_r;
    load_out       = 1'b0;
    wr_en          = 1'b0;
    wr_data        = in_stream_byte;
    rd_en          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire && !complete) begin
          case (phase_r)
            PH_CONTROL: begin
              flag_shift_nxt = in_stream_byte;
              flags_left_nxt = FLAGS_PER_CTRL;
              phase_nxt      = PH_ITEM;
            end
            PH_ITEM: begin
              if (flag_shift_r[0]) begin
                wr_en          = 1'b1;
                wr_data        = in_stream_byte;
                load_out       = 1'b1;
                pixel_nxt      = in_stream_byte;
                last_nxt       = 1'b1;
                done_nxt       = produced_inc == total_r;
                produced_nxt   = produced_inc;
                wp_nxt         = wp_inc;
                flag_shift_nxt = flag_shift_r >> 1;
                flags_left_nxt = flags_left_r - FLAG_W'(1);
                phase_nxt      = (flags_left_nxt == '0) ? PH_CONTROL : PH_ITEM;
              end else begin
                cmd_low_nxt = in_stream_byte;
                phase_nxt   = PH_HIGH;
              end
            end
            PH_HIGH: begin
              if (short_mode_r) begin
                remain_nxt = RUN_W'(cmd_word[3:0]) + LEN_BIAS;
                offset_nxt = cmd_word[15:4];
              end else begin
                remain_nxt = RUN_W'(cmd_word[4:0]) + LEN_BIAS;
                offset_nxt = {1'b0, cmd_word[15:5]};
              end
              ofs_big_nxt = DW'(offset_nxt) >= DW'(WINDOW_DEPTH);
              state_nxt   = S_READ;
            end
            default: begin
              phase_nxt = PH_CONTROL;
            end
          endcase
        end
      end
      S_READ: begin
        if (remain_r == '0 || complete) begin
          flag_shift_nxt = flag_shift_r >> 1;
          flags_left_nxt = flags_left_r - FLAG_W'(1);
          phase_nxt      = (flags_left_nxt == '0) ? PH_CONTROL : PH_ITEM;
          state_nxt      = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          bad_nxt   = (offset_r == '0) || (TOTAL_W'(offset_r) > produced_r) || ofs_big_r;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          wr_en        = 1'b1;
          wr_data      = bad_r ? '0 : rd_data;
          load_out     = 1'b1;
          pixel_nxt    = wr_data;
          done_nxt     = produced_inc == total_r;
          last_nxt     = (remain_r == RUN_W'(1)) || (produced_inc == total_r);
          produced_nxt = produced_inc;
          wp_nxt       = wp_inc;
          remain_nxt   = remain_r - RUN_W'(1);
          state_nxt    = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load_out || (out_valid_r && out_stall);

    if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_MODE: begin
          short_mode_nxt = cfg_wdata[0];
        end
        CFG_PIXEL_TOTAL: begin
          total_nxt      = cfg_wdata[TOTAL_W-1:0];
          state_nxt      = S_IDLE;
          phase_nxt      = PH_CONTROL;
          flag_shift_nxt = '0;
          flags_left_nxt = '0;
          cmd_low_nxt    = '0;
          produced_nxt   = '0;
          wp_nxt         = '0;
        end
        default: begin
          short_mode_nxt = short_mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_CONTROL;
      short_mode_r <= 1'b0;
      total_r      <= '0;
      produced_r   <= '0;
      wp_r         <= '0;
      flag_shift_r <= '0;
      flags_left_r <= '0;
      cmd_low_r    <= '0;
      remain_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      short_mode_r <= short_mode_nxt;
      total_r      <= total_nxt;
      produced_r   <= produced_nxt;
      wp_r         <= wp_nxt;
      flag_shift_r <= flag_shift_nxt;
      flags_left_r <= flags_left_nxt;
      cmd_low_r    <= cmd_low_nxt;
      remain_r     <= remain_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r  <= offset_nxt;
    ofs_big_r <= ofs_big_nxt;
    bad_r     <= bad_nxt;
    pixel_r   <= pixel_nxt;
    last_r    <= last_nxt;
    done_r    <= done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = pixel_r;
  assign out_last_of_run = last_r;
  assign out_image_done  = done_r;

  // a held pixel is never overwritten
  `LZPD_ASSERT_SAME(a_no_overwrite, out_valid_r && out_stall, !load_out)
  // the input side only opens between runs
  `LZPD_ASSERT_SAME(a_in_only_idle, !in_stall, state_r == S_IDLE)
  // the pixel count never passes the configured total
  `LZPD_ASSERT_NEXT(a_count_bound, load_out && !cfg_we, produced_r <= total_r)

endmodule
